// ===== hdl/jrms_pkg.sv =====
// ----------------------------------------------------------------------------
// jrms_pkg
// Shared types and codes for the restart marker checker: item layouts,
// commands, status codes and the one-hot phase encoding.
// ----------------------------------------------------------------------------
package jrms_pkg;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_RST_CHECK = 2'd0,
    CMD_BYTE      = 2'd1,
    CMD_WRITE_RST = 2'd2,
    CMD_DNL_CHECK = 2'd3
  } cmd_e;

  // status codes of a result item
  typedef enum logic [2:0] {
    ST_WORKING  = 3'd0,
    ST_RESTART  = 3'd1,
    ST_SKIPPED  = 3'd2,
    ST_DNL_OK   = 3'd3,
    ST_NO_DNL   = 3'd4,
    ST_MALFORM  = 3'd5,
    ST_EOF      = 3'd6,
    ST_WRITTEN  = 3'd7
  } status_e;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_PEEK   = 7'b0000010,
    PH_SCAN   = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_LEN_LO = 7'b0010000,
    PH_HGT_HI = 7'b0100000,
    PH_HGT_LO = 7'b1000000
  } phase_e;

  // marker bytes and words
  localparam logic [7:0]  FILL_BYTE  = 8'hFF;
  localparam logic [7:0]  DNL_BYTE   = 8'hDC;
  localparam logic [7:0]  RST0_BYTE  = 8'hD0;
  localparam logic [7:0]  MARK_LO    = 8'hC0;
  localparam logic [7:0]  MARK_HI    = 8'hEF;
  localparam logic [12:0] RST_WORD_HI = 13'h1FFA; // 0xFFD0 >> 3
  localparam logic [15:0] DNL_LENGTH = 16'h0004;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  bytes_returned;
    logic [15:0] marker_word;
    logic [15:0] image_height;
    logic        segment_valid;
    logic        out_of_sync;
  } out_item_t;

endpackage

// ===== hdl/jrms_core.sv =====
// ----------------------------------------------------------------------------
// jrms_core
// Parser state and the per-item decision logic. The result for the item
// presented on item_i is formed combinationally; state updates on fire_i.
// ----------------------------------------------------------------------------
module jrms_core import jrms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  logic      scan_for_dnl_i,
  output out_item_t result_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic        pending_ff_q, pending_ff_d;
  logic        dnl_seen_q, dnl_seen_d;
  logic        segment_ok_q, segment_ok_d;
  logic [15:0] field_q, field_d;
  logic        dnl_mode_q, dnl_mode_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      idx_q        <= 3'd0;
      pending_ff_q <= 1'b0;
      dnl_seen_q   <= 1'b0;
      segment_ok_q <= 1'b1;
      field_q      <= 16'd0;
      dnl_mode_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      pending_ff_q <= pending_ff_d;
      dnl_seen_q   <= dnl_seen_d;
      segment_ok_q <= segment_ok_d;
      field_q      <= field_d;
      dnl_mode_q   <= dnl_mode_d;
    end
  end

  // per-item decision
  always_comb begin
    logic [7:0]  b;
    logic        eod;
    logic [15:0] v;
    logic [2:0]  delta;
    logic [2:0]  idx_inc;
    status_e     code;
    logic [1:0]  ret;
    logic [15:0] height;
    logic [15:0] mw;
    logic        oos;

    b       = item_i.data_byte;
    eod     = item_i.end_of_data;
    v       = {field_q[7:0], b};
    delta   = b[2:0] - idx_q;
    idx_inc = idx_q + 3'd1;
    code    = ST_WORKING;
    ret     = 2'd0;
    height  = 16'd0;
    mw      = 16'd0;
    oos     = 1'b0;

    phase_d      = phase_q;
    idx_d        = idx_q;
    pending_ff_d = pending_ff_q;
    dnl_seen_d   = dnl_seen_q;
    segment_ok_d = segment_ok_q;
    field_d      = field_q;
    dnl_mode_d   = dnl_mode_q;

    case (cmd_e'(item_i.command))
      CMD_RST_CHECK: begin
        phase_d      = PH_PEEK;
        pending_ff_d = 1'b0;
        dnl_mode_d   = 1'b0;
      end
      CMD_DNL_CHECK: begin
        if (dnl_seen_q) begin
          code         = ST_DNL_OK;
          height       = field_q;
          phase_d      = PH_IDLE;
          pending_ff_d = 1'b0;
        end else begin
          phase_d      = PH_PEEK;
          pending_ff_d = 1'b0;
          dnl_mode_d   = 1'b1;
        end
      end
      CMD_WRITE_RST: begin
        mw    = {RST_WORD_HI, idx_q};
        idx_d = idx_inc;
        code  = ST_WRITTEN;
      end
      default: begin
        case (phase_q)
          PH_PEEK, PH_SCAN: begin
            // byte examined in peek or resync scan
            if (phase_q == PH_SCAN) oos = 1'b1;
            if (eod) begin
              if (phase_q == PH_PEEK && dnl_mode_q) begin
                code = ST_NO_DNL;
                ret  = {1'b0, pending_ff_q};
              end else begin
                oos  = 1'b1;
                code = ST_EOF;
              end
              phase_d      = PH_IDLE;
              pending_ff_d = 1'b0;
            end else if (!pending_ff_q) begin
              if (b == FILL_BYTE) begin
                pending_ff_d = 1'b1;
              end else if (phase_q == PH_PEEK) begin
                if (dnl_mode_q) begin
                  code    = ST_NO_DNL;
                  ret     = 2'd1;
                  phase_d = PH_IDLE;
                end else begin
                  oos     = 1'b1;
                  phase_d = PH_SCAN;
                end
              end
            end else if (phase_q == PH_PEEK && b == FILL_BYTE) begin
              // fill byte, one 0xFF stays held
            end else if (phase_q == PH_PEEK && b == DNL_BYTE &&
                         (dnl_mode_q || scan_for_dnl_i)) begin
              if (dnl_seen_q) begin
                code         = ST_DNL_OK;
                height       = field_q;
                ret          = 2'd2;
                phase_d      = PH_IDLE;
                pending_ff_d = 1'b0;
              end else begin
                pending_ff_d = 1'b0;
                phase_d      = PH_LEN_HI;
              end
            end else if (phase_q == PH_PEEK && dnl_mode_q) begin
              code         = ST_NO_DNL;
              ret          = 2'd2;
              phase_d      = PH_IDLE;
              pending_ff_d = 1'b0;
            end else begin
              // marker classification (expected restart first)
              oos     = 1'b1;
              phase_d = PH_SCAN;
              if (b[7:3] == RST0_BYTE[7:3]) begin
                if (delta == 3'd0) begin
                  idx_d        = idx_inc;
                  segment_ok_d = 1'b1;
                  code         = ST_RESTART;
                  phase_d      = PH_IDLE;
                  pending_ff_d = 1'b0;
                  if (phase_q == PH_PEEK) oos = 1'b0;
                end else if (delta[2]) begin
                  // marker behind: consumed, scan goes on
                  pending_ff_d = 1'b0;
                end else begin
                  segment_ok_d = 1'b0;
                  idx_d        = idx_inc;
                  code         = ST_SKIPPED;
                  ret          = 2'd2;
                  phase_d      = PH_IDLE;
                  pending_ff_d = 1'b0;
                end
              end else if (b inside {[MARK_LO:MARK_HI]}) begin
                segment_ok_d = 1'b0;
                idx_d        = idx_inc;
                code         = ST_SKIPPED;
                ret          = 2'd2;
                phase_d      = PH_IDLE;
                pending_ff_d = 1'b0;
              end else begin
                pending_ff_d = (b == FILL_BYTE);
              end
            end
          end
          PH_LEN_HI, PH_HGT_HI: begin
            // high byte of a DNL field
            if (eod) begin
              code         = (phase_q == PH_LEN_HI) ? ST_MALFORM : ST_EOF;
              phase_d      = PH_IDLE;
              pending_ff_d = 1'b0;
            end else begin
              field_d = {8'd0, b};
              phase_d = (phase_q == PH_LEN_HI) ? PH_LEN_LO : PH_HGT_LO;
            end
          end
          PH_LEN_LO: begin
            // length word must be four
            if (eod) begin
              code         = ST_MALFORM;
              phase_d      = PH_IDLE;
              pending_ff_d = 1'b0;
            end else begin
              field_d = v;
              if (v != DNL_LENGTH) begin
                code         = ST_MALFORM;
                phase_d      = PH_IDLE;
                pending_ff_d = 1'b0;
              end else begin
                phase_d = PH_HGT_HI;
              end
            end
          end
          PH_HGT_LO: begin
            // height word must be nonzero
            phase_d      = PH_IDLE;
            pending_ff_d = 1'b0;
            if (eod) begin
              code = ST_EOF;
            end else begin
              field_d = v;
              if (v == 16'd0) begin
                code = ST_MALFORM;
              end else begin
                dnl_seen_d = 1'b1;
                code       = ST_DNL_OK;
                height     = v;
              end
            end
          end
          default: begin
            // idle: byte ignored
          end
        endcase
      end
    endcase

    result_o.status         = code;
    result_o.bytes_returned = ret;
    result_o.marker_word    = mw;
    result_o.image_height   = height;
    result_o.segment_valid  = segment_ok_d;
    result_o.out_of_sync    = oos;
  end

  // restart found moves the expected index on by one
  a_restart_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.status == ST_RESTART |=>
      idx_q == 3'($past(idx_q) + 3'd1))
    else $error("restart index did not advance");

  // a skipped segment is reported invalid
  a_skip_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.status == ST_SKIPPED |-> !result_o.segment_valid &&
      result_o.bytes_returned == 2'd2)
    else $error("skipped segment not flagged");

  // an accepted height is remembered
  a_dnl_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.status == ST_DNL_OK |=> dnl_seen_q)
    else $error("dnl height not retained");

  // a held fill byte only exists while looking for a marker
  a_ff_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_ff_q |-> phase_q == PH_PEEK || phase_q == PH_SCAN)
    else $error("held fill byte outside marker search");

endmodule

// ===== hdl/jpeg_restart_marker_sync_top.sv =====
// An accepted item is held in the input register, passes the parser core when
// the result register can take it, and is offered from the result register.
// Throughput: one item per cycle while out_stall_i is low.
// Reset: asynchronous, active low; parser idle, restart index zero,
// segment valid, no DNL height stored, DNL scanning disabled.
// ----------------------------------------------------------------------------
// jpeg_restart_marker_sync_top
// Byte-serial restart marker checker with resync. Input register, parser
// core and result register, with valid/stall channels on both sides.
// ----------------------------------------------------------------------------
module jpeg_restart_marker_sync_top import jrms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic      scan_for_dnl_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      fire;
  logic      take;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_for_dnl_q <= 1'b0;
    end else if (cfg_we_i) begin
      scan_for_dnl_q <= cfg_wdata_i;
    end
  end

  // handshake: the core fires when the result register can take an item
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take || fire) begin
      in_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q <= in_item_i;
    end
  end

  jrms_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (in_item_q),
    .scan_for_dnl_i (scan_for_dnl_q),
    .result_o       (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
